[design/elevator_request_scheduler_unit_assert.svh]
// ----------------------------------------------------------------------------
// Elevator request scheduler assertion macros
// Short wrappers for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_REQUEST_SCHEDULER_UNIT_ASSERT_SVH
`define ELEVATOR_REQUEST_SCHEDULER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERS_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ERS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

[design/ers_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator request scheduler package
// Field widths, event codes, direction codes and register defaults.
// ----------------------------------------------------------------------------
package ers_pkg;

  localparam int NUM_FLOORS_DEF = 64;
  localparam int FLOOR_W        = 6;
  localparam int LOAD_W         = 16;
  localparam int FUNC_W         = 3;
  localparam int DIR_W          = 2;
  localparam int MASK_W         = 64;
  localparam int APB_DW         = 64;
  localparam int APB_AW         = 5;

  localparam logic [FLOOR_W-1:0] BOTTOM_RST = 6'd0;
  localparam logic [FLOOR_W-1:0] TOP_RST    = 6'd63;
  localparam logic [LOAD_W-1:0]  LIMIT_RST  = 16'd1000;

  typedef enum logic [FUNC_W-1:0] {
    FN_BUTTON   = 3'd0,
    FN_PROCESS  = 3'd1,
    FN_ENTER    = 3'd2,
    FN_EXIT     = 3'd3,
    FN_EMER_SET = 3'd4,
    FN_EMER_CLR = 3'd5
  } func_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    REG_BOTTOM = 2'd0,
    REG_TOP    = 2'd1,
    REG_SECURE = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_idx_t;

endpackage

[design/elevator_request_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator request scheduler unit
// LOOK scheduling for one car: files floor requests into up and down sets,
// serves them in travel order and tracks load and the emergency flag.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on start with in_func, in_floor and in_load_amount. busy is
//   always low, so an event is taken on every cycle that start is high.
//   Each event yields exactly one result beat, shown for one cycle with
//   out_valid high; the receiver cannot stall, so it must take every beat.
//   An event passes through the input register and then into the car state
//   and the result register, which drives out_valid. Throughput is one event
//   per cycle,
//   set by the single pass through the 64-bit priority encoders and the load
//   adder.
//   The APB port (64-bit data, registers at byte offsets 0, 8, 16, 24) sets
//   bottom floor, top floor, secure mask and load limit; write it only while
//   no event is in flight. Reset clears requests, puts the car idle at floor
//   zero with no load and no alarm, and loads the register defaults.
// ----------------------------------------------------------------------------
module elevator_request_scheduler_unit #(
  parameter int NUM_FLOORS = ers_pkg::NUM_FLOORS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // event channel
  input  logic                         start,
  output logic                         busy,
  input  logic [ers_pkg::FUNC_W-1:0]   in_func,
  input  logic [ers_pkg::FLOOR_W-1:0]  in_floor,
  input  logic [ers_pkg::LOAD_W-1:0]   in_load_amount,
  // result channel
  output logic                         out_valid,
  output logic                         out_accepted,
  output logic [ers_pkg::FLOOR_W-1:0]  out_current_floor,
  output logic [ers_pkg::DIR_W-1:0]    out_direction,
  output logic                         out_emergency,
  output logic [ers_pkg::LOAD_W-1:0]   out_load,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ers_pkg::APB_AW-1:0]   paddr,
  input  logic [ers_pkg::APB_DW-1:0]   pwdata,
  output logic [ers_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import ers_pkg::*;

  // configuration registers
  logic [FLOOR_W-1:0] bottom_r;
  logic [FLOOR_W-1:0] top_r;
  logic [MASK_W-1:0]  secure_r;
  logic [LOAD_W-1:0]  limit_r;

  // input register
  logic               stg_vld_r;
  func_t              stg_func_r;
  logic [FLOOR_W-1:0] stg_floor_r;
  logic [LOAD_W-1:0]  stg_amt_r;

  // car state
  logic [NUM_FLOORS-1:0] up_set_r, up_set_nxt;
  logic [NUM_FLOORS-1:0] down_set_r, down_set_nxt;
  logic [FLOOR_W-1:0]    floor_r, floor_nxt;
  dir_t                  dir_r, dir_nxt;
  logic                  alarm_r, alarm_nxt;
  logic [LOAD_W-1:0]     load_r, load_nxt;

  // result register
  logic out_valid_r;
  logic accepted_r, accepted_nxt;

  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  logic [FLOOR_W-1:0]    lo_idx;
  logic [FLOOR_W-1:0]    hi_idx;
  logic [NUM_FLOORS-1:0] req_bit;
  logic [NUM_FLOORS-1:0] hi_bit;
  logic [NUM_FLOORS-1:0] up_served;
  logic [NUM_FLOORS-1:0] down_served;
  logic                  btn_ok;
  logic                  proc_ok;
  logic [LOAD_W:0]       load_sum;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // ---------------------------------------------------------------- APB ----
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:3]);

  always_comb begin
    case (cfg_idx)
      REG_BOTTOM: prdata = APB_DW'(bottom_r);
      REG_TOP:    prdata = APB_DW'(top_r);
      REG_SECURE: prdata = APB_DW'(secure_r);
      REG_LIMIT:  prdata = APB_DW'(limit_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_r <= BOTTOM_RST;
      top_r    <= TOP_RST;
      secure_r <= '0;
      limit_r  <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BOTTOM: bottom_r <= pwdata[FLOOR_W-1:0];
        REG_TOP:    top_r    <= pwdata[FLOOR_W-1:0];
        REG_SECURE: secure_r <= pwdata[MASK_W-1:0];
        REG_LIMIT:  limit_r  <= pwdata[LOAD_W-1:0];
        default:    ;
      endcase
    end
  end

  // ------------------------------------------------------ input register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stg_func_r  <= func_t'(in_func);
      stg_floor_r <= in_floor;
      stg_amt_r   <= in_load_amount;
    end
  end

  // ---------------------------------------------------- priority encoders ----
  // Lowest pending up request and highest pending down request.
  always_comb begin
    lo_idx = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (up_set_r[i]) lo_idx = FLOOR_W'(i);
    end
  end

  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (down_set_r[i]) hi_idx = FLOOR_W'(i);
    end
  end

  assign req_bit     = {{(NUM_FLOORS-1){1'b0}}, 1'b1} << stg_floor_r;
  assign hi_bit      = {{(NUM_FLOORS-1){1'b0}}, 1'b1} << hi_idx;
  // Clearing the lowest set bit needs no decoder: v & (v - 1).
  assign up_served   = up_set_r & (up_set_r - NUM_FLOORS'(1));
  assign down_served = down_set_r & ~hi_bit;

  assign btn_ok = (stg_floor_r >= bottom_r) && (stg_floor_r <= top_r)
               && ({1'b0, stg_floor_r} < (FLOOR_W+1)'(NUM_FLOORS))
               && (stg_floor_r != floor_r) && !secure_r[stg_floor_r];

  assign proc_ok = (load_r <= limit_r) && !alarm_r
                && (((dir_r == DIR_UP) && (up_set_r != '0))
                 || ((dir_r == DIR_DOWN) && (down_set_r != '0)));

  assign load_sum = {1'b0, load_r} + {1'b0, stg_amt_r};

  // ---------------------------------------------------------- event logic ----
  always_comb begin
    up_set_nxt   = up_set_r;
    down_set_nxt = down_set_r;
    floor_nxt    = floor_r;
    dir_nxt      = dir_r;
    alarm_nxt    = alarm_r;
    load_nxt     = load_r;
    accepted_nxt = 1'b0;
    case (stg_func_r)
      FN_BUTTON: begin
        if (btn_ok) begin
          accepted_nxt = 1'b1;
          if (stg_floor_r < floor_r) begin
            down_set_nxt = down_set_r | req_bit;
            if (dir_r == DIR_IDLE) dir_nxt = DIR_DOWN;
          end else begin
            up_set_nxt = up_set_r | req_bit;
            if (dir_r == DIR_IDLE) dir_nxt = DIR_UP;
          end
        end
      end
      FN_PROCESS: begin
        if (proc_ok) begin
          accepted_nxt = 1'b1;
          if (dir_r == DIR_UP) begin
            up_set_nxt = up_served;
            floor_nxt  = lo_idx;
            if (up_served == '0) dir_nxt = (down_set_r != '0) ? DIR_DOWN : DIR_IDLE;
          end else begin
            down_set_nxt = down_served;
            floor_nxt    = hi_idx;
            if (down_served == '0) dir_nxt = (up_set_r != '0) ? DIR_UP : DIR_IDLE;
          end
        end
      end
      FN_ENTER:    load_nxt  = load_sum[LOAD_W] ? '1 : load_sum[LOAD_W-1:0];
      FN_EXIT:     load_nxt  = (stg_amt_r > load_r) ? '0 : load_r - stg_amt_r;
      FN_EMER_SET: alarm_nxt = 1'b1;
      FN_EMER_CLR: alarm_nxt = 1'b0;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_set_r    <= '0;
      down_set_r  <= '0;
      floor_r     <= '0;
      dir_r       <= DIR_IDLE;
      alarm_r     <= 1'b0;
      load_r      <= '0;
      out_valid_r <= 1'b0;
      accepted_r  <= 1'b0;
    end else begin
      out_valid_r <= stg_vld_r;
      if (stg_vld_r) begin
        up_set_r   <= up_set_nxt;
        down_set_r <= down_set_nxt;
        floor_r    <= floor_nxt;
        dir_r      <= dir_nxt;
        alarm_r    <= alarm_nxt;
        load_r     <= load_nxt;
        accepted_r <= accepted_nxt;
      end
    end
  end

  // The car state doubles as the result register; it only moves with a beat.
  assign out_valid         = out_valid_r;
  assign out_accepted      = accepted_r;
  assign out_current_floor = floor_r;
  assign out_direction     = dir_r;
  assign out_emergency     = alarm_r;
  assign out_load          = load_r;

  // ----------------------------------------------------------- assertions ----
`include "elevator_request_scheduler_unit_assert.svh"

  `ERS_ASSERT_NEXT(a_beat_follows, clk, rst_n, stg_vld_r, out_valid_r)
  `ERS_ASSERT_SAME(a_idle_empty, clk, rst_n, dir_r == DIR_IDLE, (up_set_r | down_set_r) == '0)
  `ERS_ASSERT_SAME(a_up_pending, clk, rst_n, dir_r == DIR_UP, up_set_r != '0)
  `ERS_ASSERT_SAME(a_down_pending, clk, rst_n, dir_r == DIR_DOWN, down_set_r != '0)

endmodule
